/* src/chc_pkg.sv */
package chc_pkg;

    // Default geometry of the evaluator
    localparam int COORD_WIDTH_DEF = 21;
    localparam int U_FRAC_BITS_DEF = 16;

    // Fixed field widths
    localparam int ORDER_WIDTH     = 2;
    localparam int MAX_ORDER_WIDTH = 3;
    localparam int OUT_WIDTH       = 48;
    localparam int CFG_DATA_WIDTH  = 63;
    localparam int CFG_INDEX_WIDTH = 2;

    // Basis values carry 16 fractional bits and reach +/-12.0
    localparam int BASIS_FRAC  = 16;
    localparam int BASIS_WIDTH = BASIS_FRAC + 5;

    // Depth of the queue between front and back
    localparam int FIFO_DEPTH = 4;

    // Configuration register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_START_POINT   = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_END_POINT     = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_START_TANGENT = 2'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_END_TANGENT   = 2'd3;

    // Derivative orders
    localparam logic [ORDER_WIDTH-1:0] ORDER_POS  = 2'd0;
    localparam logic [ORDER_WIDTH-1:0] ORDER_VEL  = 2'd1;
    localparam logic [ORDER_WIDTH-1:0] ORDER_ACC  = 2'd2;
    localparam logic [ORDER_WIDTH-1:0] ORDER_JERK = 2'd3;

    // Classification of one queued transaction
    typedef struct packed {
        logic                   err;
        logic [ORDER_WIDTH-1:0] order;
    } ctrl_t;

    localparam int CTRL_WIDTH = $bits(ctrl_t);

endpackage

/* src/cubic_hermite_curve_derivatives_core.sv */
// A transaction passes the front stages, the queue, and the basis, product and output
// registers before its first result. Throughput: one result per cycle while out_ready
// is high; a transaction asking for order n yields n+1 results (an error transaction one).
// Input transactions are taken every cycle while the 4-entry queue has room.
// Reset (rst_n low, asynchronous) empties the pipeline and clears the segment registers.
module cubic_hermite_curve_derivatives_core import chc_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int U_FRAC_BITS = U_FRAC_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write,
    input  logic [CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]   cfg_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [U_FRAC_BITS:0]        param_u,
    input  logic [MAX_ORDER_WIDTH-1:0]  max_order,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [ORDER_WIDTH-1:0]      order_index,
    output logic signed [OUT_WIDTH-1:0] coord_x,
    output logic signed [OUT_WIDTH-1:0] coord_y,
    output logic signed [OUT_WIDTH-1:0] coord_z,
    output logic                        valid_flag,
    output logic                        last_flag
);

    localparam int Q_WIDTH = CTRL_WIDTH + 3 * (U_FRAC_BITS + 1);

    logic               fq_valid, fq_ready;
    logic [Q_WIDTH-1:0] fq_data;
    logic               qb_valid, qb_ready;
    logic [Q_WIDTH-1:0] qb_data;

    // Accept and classify, form u^2 and u^3
    chc_front #(
        .U_FRAC_BITS (U_FRAC_BITS),
        .Q_WIDTH     (Q_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .param_u   (param_u),
        .max_order (max_order),
        .q_valid   (fq_valid),
        .q_ready   (fq_ready),
        .q_data    (fq_data)
    );

    // Decouple front from back
    chc_fifo #(
        .WIDTH (Q_WIDTH),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_data  (fq_data),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_data   (qb_data)
    );

    // Expand each transaction into one result per order
    chc_back #(
        .COORD_WIDTH (COORD_WIDTH),
        .U_FRAC_BITS (U_FRAC_BITS),
        .Q_WIDTH     (Q_WIDTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .q_valid     (qb_valid),
        .q_ready     (qb_ready),
        .q_data      (qb_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .order_index (order_index),
        .coord_x     (coord_x),
        .coord_y     (coord_y),
        .coord_z     (coord_z),
        .valid_flag  (valid_flag),
        .last_flag   (last_flag)
    );

endmodule

/* src/chc_front.sv */
module chc_front import chc_pkg::*; #(
    parameter int U_FRAC_BITS = U_FRAC_BITS_DEF,
    parameter int Q_WIDTH     = CTRL_WIDTH + 3 * (U_FRAC_BITS + 1)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [U_FRAC_BITS:0]       param_u,
    input  logic [MAX_ORDER_WIDTH-1:0] max_order,
    output logic                       q_valid,
    input  logic                       q_ready,
    output logic [Q_WIDTH-1:0]         q_data
);

    localparam int UW = U_FRAC_BITS + 1;

    logic          v1_reg, v1_next;
    logic [UW-1:0] u1_reg;
    ctrl_t         ctrl1_reg;
    logic          v2_reg, v2_next;
    logic [UW-1:0] u2u_reg;
    logic [UW-1:0] usq_reg;
    ctrl_t         ctrl2_reg;

    logic          can1, can2;
    logic          accept;
    logic          u_over;
    ctrl_t         ctrl_in;
    logic [2*UW-1:0] sq_full;
    logic [2*UW-1:0] cube_full;

    // Stall chain: a stage moves when the one after it is free or moving
    assign can2     = !v2_reg || q_ready;
    assign can1     = !v1_reg || can2;
    assign in_ready = can1;
    assign accept   = in_valid && can1;

    // Classify: u above 1.0 or order above 3 is an error transaction
    always_comb
    begin
        u_over        = param_u[U_FRAC_BITS] && (|param_u[U_FRAC_BITS-1:0]);
        ctrl_in.err   = u_over || (max_order > MAX_ORDER_WIDTH'(ORDER_JERK));
        ctrl_in.order = max_order[ORDER_WIDTH-1:0];
    end

    // Square and cube of u, each truncated back to U_FRAC_BITS fraction bits
    assign sq_full   = (2*UW)'(u1_reg) * (2*UW)'(u1_reg);
    assign cube_full = (2*UW)'(usq_reg) * (2*UW)'(u2u_reg);

    assign v1_next = accept ? 1'b1 : (can2 ? 1'b0 : v1_reg);
    assign v2_next = can2 ? v1_reg : v2_reg;

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
        end
    end

    // Payload: capture input, then square
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            u1_reg    <= param_u;
            ctrl1_reg <= ctrl_in;
        end
        if (can2 && v1_reg)
        begin
            u2u_reg   <= u1_reg;
            usq_reg   <= sq_full[U_FRAC_BITS +: UW];
            ctrl2_reg <= ctrl1_reg;
        end
    end

    // Push {ctrl, u, u^2, u^3} into the queue
    assign q_valid = v2_reg;
    assign q_data  = {ctrl2_reg, u2u_reg, usq_reg, cube_full[U_FRAC_BITS +: UW]};

endmodule

/* src/chc_fifo.sv */
module chc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != NW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_data   = mem_reg[rd_ptr_reg];

    // Advance pointers with wrap at the depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* src/chc_back.sv */
module chc_back import chc_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int U_FRAC_BITS = U_FRAC_BITS_DEF,
    parameter int Q_WIDTH     = CTRL_WIDTH + 3 * (U_FRAC_BITS + 1)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write,
    input  logic [CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]   cfg_data,
    input  logic                        q_valid,
    output logic                        q_ready,
    input  logic [Q_WIDTH-1:0]          q_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [ORDER_WIDTH-1:0]      order_index,
    output logic signed [OUT_WIDTH-1:0] coord_x,
    output logic signed [OUT_WIDTH-1:0] coord_y,
    output logic signed [OUT_WIDTH-1:0] coord_z,
    output logic                        valid_flag,
    output logic                        last_flag
);

    localparam int UW  = U_FRAC_BITS + 1;
    localparam int BW  = U_FRAC_BITS + 6;
    localparam int SHR = (U_FRAC_BITS >= BASIS_FRAC) ? U_FRAC_BITS - BASIS_FRAC : 0;
    localparam int SHL = (U_FRAC_BITS < BASIS_FRAC) ? BASIS_FRAC - U_FRAC_BITS : 0;
    localparam int XW  = BW + SHL;
    localparam int RW  = 3 * COORD_WIDTH;
    localparam int PW  = COORD_WIDTH + BASIS_WIDTH;

    localparam logic signed [BW-1:0] ONE = BW'(1) << U_FRAC_BITS;
    localparam logic signed [BW-1:0] C2  = BW'(2);
    localparam logic signed [BW-1:0] C3  = BW'(3);
    localparam logic signed [BW-1:0] C4  = BW'(4);
    localparam logic signed [BW-1:0] C6  = BW'(6);
    localparam logic signed [BW-1:0] C12 = BW'(12);

    // Segment registers
    logic [RW-1:0] cfg_reg [4];

    // Sequencer
    logic [ORDER_WIDTH-1:0] k_reg, k_next;
    ctrl_t                  head_ctrl;
    logic [UW-1:0]          head_u, head_u2, head_u3;
    logic                   issue, head_last;

    // Basis stage
    logic                          b_valid_reg;
    logic signed [BASIS_WIDTH-1:0] b_reg [4];
    logic [ORDER_WIDTH-1:0]        b_order_reg;
    logic                          b_last_reg;
    logic                          b_ok_reg;
    logic signed [BW-1:0]          b_raw [4];
    logic signed [BASIS_WIDTH-1:0] b_scaled [4];

    // Product stage
    logic                   c_valid_reg;
    logic signed [PW-1:0]   p_reg [3][4];
    logic [ORDER_WIDTH-1:0] c_order_reg;
    logic                   c_last_reg;
    logic                   c_ok_reg;

    // Output register
    logic                        out_valid_reg;
    logic signed [OUT_WIDTH-1:0] sum [3];

    logic can_out, can_c, can_b;

    // Store configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < 4; j++)
            begin
                cfg_reg[j] <= '0;
            end
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_START_POINT:   cfg_reg[0] <= cfg_data[RW-1:0];
                REG_END_POINT:     cfg_reg[1] <= cfg_data[RW-1:0];
                REG_START_TANGENT: cfg_reg[2] <= cfg_data[RW-1:0];
                REG_END_TANGENT:   cfg_reg[3] <= cfg_data[RW-1:0];
                default:           ;
            endcase
        end
    end

    // Stall chain from the result port back to the queue
    assign can_out = !out_valid_reg || out_ready;
    assign can_c   = !c_valid_reg || can_out;
    assign can_b   = !b_valid_reg || can_c;

    // Unpack queue head
    assign head_ctrl = ctrl_t'(q_data[Q_WIDTH-1 -: CTRL_WIDTH]);
    assign head_u    = q_data[3*UW-1 -: UW];
    assign head_u2   = q_data[2*UW-1 -: UW];
    assign head_u3   = q_data[UW-1:0];

    // Issue one order per cycle while the basis stage can move; pop with the last one
    assign issue     = q_valid && can_b;
    assign head_last = head_ctrl.err || (k_reg == head_ctrl.order);
    assign q_ready   = can_b && head_last;
    assign k_next    = issue ? (head_last ? '0 : k_reg + 1'b1) : k_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg <= '0;
        end
        else
        begin
            k_reg <= k_next;
        end
    end

    // Hermite basis for the current order, then scale to 16 fraction bits
    always_comb
    begin
        logic signed [BW-1:0] su, su2, su3;
        logic signed [XW-1:0] bx;
        su  = $signed(BW'(head_u));
        su2 = $signed(BW'(head_u2));
        su3 = $signed(BW'(head_u3));
        case (k_reg)
            ORDER_POS:
            begin
                b_raw[0] = C2 * su3 - C3 * su2 + ONE;
                b_raw[1] = C3 * su2 - C2 * su3;
                b_raw[2] = su3 - C2 * su2 + su;
                b_raw[3] = su3 - su2;
            end
            ORDER_VEL:
            begin
                b_raw[0] = C6 * su2 - C6 * su;
                b_raw[1] = C6 * su - C6 * su2;
                b_raw[2] = C3 * su2 - C4 * su + ONE;
                b_raw[3] = C3 * su2 - C2 * su;
            end
            ORDER_ACC:
            begin
                b_raw[0] = C12 * su - C6 * ONE;
                b_raw[1] = C6 * ONE - C12 * su;
                b_raw[2] = C6 * su - C4 * ONE;
                b_raw[3] = C6 * su - C2 * ONE;
            end
            default:
            begin
                b_raw[0] = C12 * ONE;
                b_raw[1] = -(C12 * ONE);
                b_raw[2] = C6 * ONE;
                b_raw[3] = C6 * ONE;
            end
        endcase
        for (int j = 0; j < 4; j++)
        begin
            bx          = XW'(b_raw[j]);
            b_scaled[j] = head_ctrl.err ? '0 : BASIS_WIDTH'((bx >>> SHR) <<< SHL);
        end
    end

    // Valid bits of the basis, product and output stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (can_b)
            begin
                b_valid_reg <= issue;
            end
            if (can_c)
            begin
                c_valid_reg <= b_valid_reg;
            end
            if (can_out)
            begin
                out_valid_reg <= c_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            b_reg       <= b_scaled;
            b_order_reg <= head_ctrl.err ? ORDER_POS : k_reg;
            b_last_reg  <= head_last;
            b_ok_reg    <= !head_ctrl.err;
        end
    end

    // Twelve coordinate-by-basis products
    always_ff @(posedge clk)
    begin
        if (can_c && b_valid_reg)
        begin
            for (int c = 0; c < 3; c++)
            begin
                for (int j = 0; j < 4; j++)
                begin
                    p_reg[c][j] <= $signed(cfg_reg[j][c*COORD_WIDTH +: COORD_WIDTH])
                                   * b_reg[j];
                end
            end
            c_order_reg <= b_order_reg;
            c_last_reg  <= b_last_reg;
            c_ok_reg    <= b_ok_reg;
        end
    end

    // Sum the four terms of each component
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            sum[c] = OUT_WIDTH'(p_reg[c][0]) + OUT_WIDTH'(p_reg[c][1])
                   + OUT_WIDTH'(p_reg[c][2]) + OUT_WIDTH'(p_reg[c][3]);
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (can_out && c_valid_reg)
        begin
            order_index <= c_order_reg;
            coord_x     <= sum[0];
            coord_y     <= sum[1];
            coord_z     <= sum[2];
            valid_flag  <= c_ok_reg;
            last_flag   <= c_last_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule
